>>> src/eas_pkg.sv
package eas_pkg;

    localparam int unsigned IMAGE_WIDTH  = 4096;
    localparam int unsigned IMAGE_HEIGHT = 4096;
    localparam int unsigned QUEUE_DEPTH  = 4;
    localparam int unsigned DIV_STEPS    = 51;

    localparam logic [18:0]        COUNT_MAX = 19'h7FFFF;
    localparam logic signed [50:0] FLUX_MAX  = {1'b0, {50{1'b1}}};
    localparam logic signed [50:0] FLUX_MIN  = {1'b1, {50{1'b0}}};
    localparam logic signed [31:0] S32_MAX   = {1'b0, {31{1'b1}}};
    localparam logic signed [31:0] S32_MIN   = {1'b1, {31{1'b0}}};

    typedef enum logic [2:0] {
        REG_CENTER_X  = 3'd0,
        REG_CENTER_Y  = 3'd1,
        REG_AXIS_A    = 3'd2,
        REG_AXIS_B    = 3'd3,
        REG_COS_ANGLE = 3'd4,
        REG_SIN_ANGLE = 3'd5,
        REG_SKY_LEVEL = 3'd6,
        REG_NOISE_GAIN = 3'd7
    } cfg_idx_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DIV,
        BK_MEAN,
        BK_MUL,
        BK_OUT
    } bk_state_t;

    typedef struct packed {
        logic [15:0]        center_x;
        logic [15:0]        center_y;
        logic [11:0]        axis_a;
        logic [11:0]        axis_b;
        logic signed [15:0] cos_angle;
        logic signed [15:0] sin_angle;
        logic signed [31:0] sky_level;
        logic [15:0]        noise_gain;
    } cfg_t;

    typedef struct packed {
        logic               func;
        logic               core;
        logic               halo;
        logic signed [31:0] pix;
        logic signed [31:0] noi;
    } q_item_t;

endpackage

>>> src/eas_queue.sv
module eas_queue
    import eas_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  q_item_t push_data,
    input  logic    pop,
    output q_item_t pop_data,
    output logic    full,
    output logic    empty
);

    localparam int unsigned PW = $clog2(QUEUE_DEPTH);

    q_item_t        mem_reg [QUEUE_DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [PW:0]    cnt_reg, cnt_next;

    assign full     = (cnt_reg == (PW+1)'(QUEUE_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg + PW'(push);
        rd_ptr_next = rd_ptr_reg + PW'(pop);
        cnt_next    = cnt_reg + (PW+1)'(push) - (PW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> src/eas_front.sv
module eas_front
    import eas_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  cfg_t               cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               in_func,
    input  logic [11:0]        in_col,
    input  logic [11:0]        in_row,
    input  logic signed [31:0] in_pix,
    input  logic signed [31:0] in_noi,
    output logic               q_push,
    output q_item_t            q_data,
    input  logic               q_full
);

    localparam int unsigned NSTG = 7;

    typedef struct packed {
        logic               func;
        logic               box;
        logic signed [31:0] pix;
        logic signed [31:0] noi;
    } side_t;

    function automatic logic in_span(input logic [11:0] pos, input logic [15:0] c,
                                     input logic [12:0] m, input logic [16:0] limit);
        logic signed [17:0] lo;
        logic [11:0]        start;
        lo    = $signed({2'b00, c}) - $signed({5'b00000, m});
        start = (!lo[17] && lo != '0) ? lo[15:4] : 12'd0;
        return (pos >= start) && ({1'b0, pos, 4'b0000} < (17'(c) + 17'(m)))
               && (17'(pos) < limit);
    endfunction

    logic [NSTG-1:0] v_reg;
    side_t           side_reg [NSTG];
    logic            en;

    logic signed [32:0] pxc_reg, pys_reg, pyc_reg, pxs_reg;
    logic [23:0]        ab1_reg, ab2_reg;
    logic [33:0]        ua_reg, va_reg;
    logic [45:0]        ub_reg, vb_reg;
    logic [47:0]        abq3_reg, abq4_reg, abq5_reg;
    logic [45:0]        hha_reg, hla_reg, lla_reg, hhb_reg, hlb_reg, llb_reg;
    logic [92:0]        l1_reg;
    logic               core6_reg, core7_reg, halo7_reg;
    logic [97:0]        l25_reg;
    logic [53:0]        r36_reg;

    logic signed [16:0] dx, dy;
    logic [12:0]        m_box;
    logic               box_next;
    logic signed [33:0] u_next, v_next;
    logic [91:0]        sqa, sqb;
    logic [92:0]        l1_next;
    logic [97:0]        l25_next;
    logic [53:0]        r36_next;
    side_t              side_next;

    assign en       = !(v_reg[NSTG-1] && q_full);
    assign in_ready = en && aresetn;
    assign q_push   = v_reg[NSTG-1] && !q_full;

    always_comb begin
        dx = $signed({1'b0, in_col, 4'b0000}) - $signed({1'b0, cfg.center_x});
        dy = $signed({1'b0, in_row, 4'b0000}) - $signed({1'b0, cfg.center_y});
        m_box = (cfg.axis_a > cfg.axis_b) ? 13'(cfg.axis_a) + 13'd32
                                          : 13'(cfg.axis_b) + 13'd32;
        box_next = in_span(in_col, cfg.center_x, m_box, 17'(IMAGE_WIDTH))
                && in_span(in_row, cfg.center_y, m_box, 17'(IMAGE_HEIGHT));
        side_next = '{func: in_func, box: box_next, pix: in_pix, noi: in_noi};
        u_next = 34'(pxc_reg) + 34'(pys_reg);
        v_next = 34'(pyc_reg) - 34'(pxs_reg);
        sqa = 92'({hha_reg, 46'b0}) + 92'({hla_reg, 24'b0}) + 92'(lla_reg);
        sqb = 92'({hhb_reg, 46'b0}) + 92'({hlb_reg, 24'b0}) + 92'(llb_reg);
        l1_next  = 93'(sqa) + 93'(sqb);
        l25_next = (98'(l1_reg) << 4) + (98'(l1_reg) << 3) + 98'(l1_reg);
        r36_next = (54'(abq5_reg) << 5) + (54'(abq5_reg) << 2);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[NSTG-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= side_next;
            for (int i = 1; i < NSTG; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
            pxc_reg <= dx * cfg.cos_angle;
            pys_reg <= dy * cfg.sin_angle;
            pyc_reg <= dy * cfg.cos_angle;
            pxs_reg <= dx * cfg.sin_angle;
            ab1_reg <= 24'(cfg.axis_a) * 24'(cfg.axis_b);
            ua_reg  <= u_next[33] ? 34'(-u_next) : 34'(u_next);
            va_reg  <= v_next[33] ? 34'(-v_next) : 34'(v_next);
            ab2_reg <= ab1_reg;
            ub_reg  <= 46'(ua_reg) * 46'(cfg.axis_b);
            vb_reg  <= 46'(va_reg) * 46'(cfg.axis_a);
            abq3_reg <= 48'(ab2_reg) * 48'(ab2_reg);
            hha_reg <= 46'(ub_reg[45:23]) * 46'(ub_reg[45:23]);
            hla_reg <= 46'(ub_reg[45:23]) * 46'(ub_reg[22:0]);
            lla_reg <= 46'(ub_reg[22:0]) * 46'(ub_reg[22:0]);
            hhb_reg <= 46'(vb_reg[45:23]) * 46'(vb_reg[45:23]);
            hlb_reg <= 46'(vb_reg[45:23]) * 46'(vb_reg[22:0]);
            llb_reg <= 46'(vb_reg[22:0]) * 46'(vb_reg[22:0]);
            abq4_reg <= abq3_reg;
            l1_reg   <= l1_next;
            abq5_reg <= abq4_reg;
            core6_reg <= l1_reg < 93'({abq5_reg, 28'b0});
            l25_reg   <= l25_next;
            r36_reg   <= r36_next;
            core7_reg <= core6_reg;
            halo7_reg <= l25_reg < 98'({r36_reg, 28'b0});
        end
    end

    assign q_data = '{func: side_reg[NSTG-1].func,
                      core: side_reg[NSTG-1].box && core7_reg,
                      halo: side_reg[NSTG-1].box && halo7_reg,
                      pix:  side_reg[NSTG-1].pix,
                      noi:  side_reg[NSTG-1].noi};

endmodule

>>> src/eas_back.sv
module eas_back
    import eas_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  cfg_t               cfg,
    input  q_item_t            q_data,
    input  logic               q_empty,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] out_pixel,
    output logic signed [31:0] out_noise,
    output logic               out_core,
    output logic               out_halo,
    output logic signed [50:0] out_flux,
    output logic [18:0]        out_count,
    output logic signed [31:0] out_mean
);

    bk_state_t state_reg, state_next;

    q_item_t            item_reg;
    logic signed [50:0] flux_reg, flux_next;
    logic [18:0]        count_reg, count_next;
    logic signed [31:0] mean_reg, mean_next;
    logic               phase_reg, phase_next;
    logic [50:0]        dvd_reg, dvd_next;
    logic [18:0]        rem_reg, rem_next;
    logic               neg_reg;
    logic [5:0]         step_reg, step_next;
    logic signed [48:0] prod_reg;
    logic               ov_reg, ov_next;

    logic signed [31:0] opix_reg, onoi_reg, omean_reg;
    logic               ocore_reg, ohalo_reg;
    logic signed [50:0] oflux_reg;
    logic [18:0]        ocount_reg;

    logic [19:0]        trial;
    logic               qbit;
    logic signed [32:0] ms;
    logic signed [32:0] dflux;
    logic signed [50:0] base_flux;
    logic [18:0]        base_count;
    logic signed [51:0] fsum;
    logic signed [32:0] dpix;
    logic signed [40:0] qn;
    logic signed [41:0] nsum;
    logic signed [31:0] npix, nnoi;
    logic               load;

    assign out_valid = ov_reg;
    assign out_pixel = opix_reg;
    assign out_noise = onoi_reg;
    assign out_core  = ocore_reg;
    assign out_halo  = ohalo_reg;
    assign out_flux  = oflux_reg;
    assign out_count = ocount_reg;
    assign out_mean  = omean_reg;

    always_comb begin
        trial = {rem_reg, dvd_reg[50]};
        qbit  = trial >= {1'b0, count_reg};
        ms    = 33'(mean_reg) + 33'(cfg.sky_level);
        dflux = 33'(item_reg.pix) - 33'(cfg.sky_level);
        base_flux  = phase_reg ? 51'sd0 : flux_reg;
        base_count = phase_reg ? 19'd0 : count_reg;
        fsum  = 52'(base_flux) + 52'(dflux);
        dpix  = 33'(item_reg.pix) - 33'(mean_reg);
        qn    = 41'(prod_reg >>> 8);
        nsum  = 42'(item_reg.noi) + 42'(qn);
        if (dpix[32] != dpix[31]) begin
            npix = dpix[32] ? S32_MIN : S32_MAX;
        end else begin
            npix = dpix[31:0];
        end
        if (nsum > 42'(S32_MAX)) begin
            nnoi = S32_MAX;
        end else if (nsum < 42'(S32_MIN)) begin
            nnoi = S32_MIN;
        end else begin
            nnoi = nsum[31:0];
        end
    end

    always_comb begin
        state_next = state_reg;
        flux_next  = flux_reg;
        count_next = count_reg;
        mean_next  = mean_reg;
        phase_next = phase_reg;
        dvd_next   = dvd_reg;
        rem_next   = rem_reg;
        step_next  = step_reg;
        ov_next    = ov_reg && !out_ready;
        q_pop      = 1'b0;
        load       = 1'b0;
        unique case (state_reg)
            BK_IDLE: begin
                if (!q_empty) begin
                    q_pop = 1'b1;
                    if (q_data.func && !phase_reg) begin
                        dvd_next   = flux_reg[50] ? 51'(-flux_reg) : 51'(flux_reg);
                        rem_next   = '0;
                        step_next  = '0;
                        state_next = BK_DIV;
                    end else begin
                        state_next = BK_MUL;
                    end
                end
            end
            BK_DIV: begin
                rem_next  = qbit ? 19'(trial - {1'b0, count_reg}) : trial[18:0];
                dvd_next  = {dvd_reg[49:0], qbit};
                step_next = step_reg + 6'd1;
                if (step_reg == 6'(DIV_STEPS - 1)) begin
                    state_next = BK_MEAN;
                end
            end
            BK_MEAN: begin
                if (count_reg == '0) begin
                    mean_next = '0;
                end else if (neg_reg) begin
                    mean_next = (dvd_reg > 51'h80000000) ? S32_MIN : 32'(-dvd_reg);
                end else begin
                    mean_next = (dvd_reg > 51'h7FFFFFFF) ? S32_MAX : dvd_reg[31:0];
                end
                phase_next = 1'b1;
                state_next = BK_MUL;
            end
            BK_MUL: begin
                if (!item_reg.func) begin
                    flux_next  = base_flux;
                    count_next = base_count;
                    if (phase_reg) begin
                        mean_next  = '0;
                        phase_next = 1'b0;
                    end
                    if (item_reg.core) begin
                        if (fsum[51] != fsum[50]) begin
                            flux_next = fsum[51] ? FLUX_MIN : FLUX_MAX;
                        end else begin
                            flux_next = fsum[50:0];
                        end
                        if (base_count != COUNT_MAX) begin
                            count_next = base_count + 19'd1;
                        end
                    end
                end
                state_next = BK_OUT;
            end
            BK_OUT: begin
                if (!ov_reg || out_ready) begin
                    load       = 1'b1;
                    ov_next    = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
            flux_reg  <= '0;
            count_reg <= '0;
            mean_reg  <= '0;
            phase_reg <= 1'b0;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            flux_reg  <= flux_next;
            count_reg <= count_next;
            mean_reg  <= mean_next;
            phase_reg <= phase_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        step_reg <= step_next;
        prod_reg <= $signed({1'b0, cfg.noise_gain}) * ms;
        if (q_pop) begin
            item_reg <= q_data;
            neg_reg  <= flux_reg[50];
        end
        if (load) begin
            opix_reg   <= (item_reg.func && item_reg.core) ? npix : item_reg.pix;
            onoi_reg   <= (item_reg.func && item_reg.halo) ? nnoi : item_reg.noi;
            ocore_reg  <= item_reg.core;
            ohalo_reg  <= item_reg.halo;
            oflux_reg  <= flux_reg;
            ocount_reg <= count_reg;
            omean_reg  <= mean_reg;
        end
    end

endmodule

>>> src/elliptical_aperture_subtract.sv
// Channel  Direction  Accept               Content
// s_       in         s_tvalid & s_tready  tuser: func; tdata: col, row, pixel, noise
// m_       out        m_tvalid & m_tready  tdata: new pixel, new noise, flags, totals, mean
// cfg_     in         cfg_valid&cfg_ready  cfg_index: register, cfg_data: value
// The front classifies a request in a pipeline; the back then works on one request at a
// time and pops the next one from the queue only when it is idle again.
// The first apply request after a measure pass also runs the serial mean divider.
// Reset is synchronous and clears the queue, the pipeline valid bits and the totals.
// A stalled result holds the back; the four-entry queue lets the front keep accepting.
module elliptical_aperture_subtract
    import eas_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [87:0]  s_tdata,   // col[11:0], row[23:12], pixel_value[55:24], noise_value[87:56]
    input  logic         s_tuser,   // func
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [167:0] m_tdata,   // new_pixel, new_noise, inside_core, inside_halo,
                                    // flux_total, pixel_count, mean_out
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    cfg_t    cfg_reg, cfg_next;
    q_item_t q_in, q_out;
    logic    q_push, q_pop, q_full, q_empty;

    logic signed [31:0] o_pixel, o_noise, o_mean;
    logic               o_core, o_halo;
    logic signed [50:0] o_flux;
    logic [18:0]        o_count;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_idx_t'(cfg_index))
                REG_CENTER_X:   cfg_next.center_x   = cfg_data[15:0];
                REG_CENTER_Y:   cfg_next.center_y   = cfg_data[15:0];
                REG_AXIS_A:     cfg_next.axis_a     = cfg_data[11:0];
                REG_AXIS_B:     cfg_next.axis_b     = cfg_data[11:0];
                REG_COS_ANGLE:  cfg_next.cos_angle  = cfg_data[15:0];
                REG_SIN_ANGLE:  cfg_next.sin_angle  = cfg_data[15:0];
                REG_SKY_LEVEL:  cfg_next.sky_level  = cfg_data;
                REG_NOISE_GAIN: cfg_next.noise_gain = cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{center_x: 16'd0, center_y: 16'd0, axis_a: 12'd0, axis_b: 12'd0,
                         cos_angle: 16'sd16384, sin_angle: 16'sd0, sky_level: 32'sd0,
                         noise_gain: 16'd256};
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    eas_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_func  (s_tuser),
        .in_col   (s_tdata[11:0]),
        .in_row   (s_tdata[23:12]),
        .in_pix   (s_tdata[55:24]),
        .in_noi   (s_tdata[87:56]),
        .q_push   (q_push),
        .q_data   (q_in),
        .q_full   (q_full)
    );

    eas_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .pop_data  (q_out),
        .full      (q_full),
        .empty     (q_empty)
    );

    eas_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .q_data    (q_out),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_pixel (o_pixel),
        .out_noise (o_noise),
        .out_core  (o_core),
        .out_halo  (o_halo),
        .out_flux  (o_flux),
        .out_count (o_count),
        .out_mean  (o_mean)
    );

    assign m_tdata = {o_mean, o_count, o_flux, o_halo, o_core, o_noise, o_pixel};

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_push && q_full)) else $error("queue written while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_pop && q_empty)) else $error("queue read while empty");

    a_core_in_halo: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(o_core && !o_halo)) else $error("core pixel outside halo");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid) else $error("result valid after reset");

endmodule

>>> tb/sv/tb_elliptical_aperture_subtract.sv
module tb_elliptical_aperture_subtract
    import eas_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [87:0]  s_tdata;   // col, row, pixel_value, noise_value
    logic         s_tuser;   // func
    logic         m_tvalid;
    logic         m_tready;
    logic [167:0] m_tdata;   // new_pixel, new_noise, inside_core, inside_halo,
                             // flux_total, pixel_count, mean_out
    logic         cfg_valid;
    logic         cfg_ready;
    logic [2:0]   cfg_index;
    logic [31:0]  cfg_data;

    typedef struct packed {
        logic signed [31:0] mean_out;
        logic [18:0]        pixel_count;
        logic signed [50:0] flux_total;
        logic               inside_halo;
        logic               inside_core;
        logic signed [31:0] new_noise;
        logic signed [31:0] new_pixel;
    } aperture_result_t;

    localparam int unsigned RESULT_BITS = $bits(aperture_result_t);

    elliptical_aperture_subtract i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    cfg_t             shadow_cfg;
    logic signed [50:0] sum_flux;
    logic [18:0]      sum_count;
    logic signed [31:0] sum_mean;
    logic             in_apply;
    aperture_result_t expected_pixels[$];
    int               error_count;
    int               stall_max;

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    initial begin
        #200ms;
        $display("*** FAILED ***");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic logic span_hit(input logic [11:0] pos, input logic [15:0] centre,
                                      input longint m, input longint limit);
        longint lo;
        longint start;
        lo = longint'(centre) - m;
        start = lo > 0 ? lo / 16 : 0;
        return longint'(pos) >= start && longint'(pos) * 16 < longint'(centre) + m
               && longint'(pos) < limit;
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic aperture_result_t predict_pixel(input logic func,
            input logic [11:0] col, input logic [11:0] row,
            input logic signed [31:0] pix, input logic signed [31:0] noi);
        aperture_result_t r;
        longint m;
        logic signed [127:0] dx;
        logic signed [127:0] dy;
        logic signed [127:0] u;
        logic signed [127:0] v;
        logic signed [127:0] a;
        logic signed [127:0] b;
        logic signed [127:0] lhs;
        logic signed [127:0] rhs;
        longint prod;
        longint q;
        longint qf;
        r.inside_core = 1'b0;
        r.inside_halo = 1'b0;
        r.new_pixel = pix;
        r.new_noise = noi;
        m = longint'(shadow_cfg.axis_a > shadow_cfg.axis_b ? shadow_cfg.axis_a
                                                            : shadow_cfg.axis_b) + 32;
        if (span_hit(col, shadow_cfg.center_x, m, IMAGE_WIDTH) &&
            span_hit(row, shadow_cfg.center_y, m, IMAGE_HEIGHT)) begin
            dx = 128'(col) * 16 - 128'(shadow_cfg.center_x);
            dy = 128'(row) * 16 - 128'(shadow_cfg.center_y);
            u = dx * 128'(shadow_cfg.cos_angle) + dy * 128'(shadow_cfg.sin_angle);
            v = dy * 128'(shadow_cfg.cos_angle) - dx * 128'(shadow_cfg.sin_angle);
            a = 128'(shadow_cfg.axis_a);
            b = 128'(shadow_cfg.axis_b);
            lhs = u * u * b * b + v * v * a * a;
            rhs = (a * a * b * b) <<< 28;
            r.inside_core = lhs < rhs;
            r.inside_halo = 25 * lhs < 36 * rhs;
        end
        if (!func) begin
            if (in_apply) begin
                sum_flux = '0;
                sum_count = '0;
                sum_mean = '0;
                in_apply = 1'b0;
            end
            if (r.inside_core) begin
                sum_flux = 51'(clamp(longint'(sum_flux) + longint'(pix)
                                     - longint'(shadow_cfg.sky_level),
                                     longint'(FLUX_MIN), longint'(FLUX_MAX)));
                if (sum_count != COUNT_MAX)
                    sum_count++;
            end
        end else begin
            if (!in_apply) begin
                sum_mean = sum_count == 0 ? 32'sd0
                         : 32'(clamp(longint'(sum_flux) / longint'(sum_count),
                                     longint'(S32_MIN), longint'(S32_MAX)));
                in_apply = 1'b1;
            end
            if (r.inside_core)
                r.new_pixel = 32'(clamp(longint'(pix) - longint'(sum_mean),
                                        longint'(S32_MIN), longint'(S32_MAX)));
            if (r.inside_halo) begin
                prod = longint'(shadow_cfg.noise_gain)
                       * (longint'(sum_mean) + longint'(shadow_cfg.sky_level));
                q = prod / 256;
                qf = (prod % 256 != 0 && prod < 0) ? q - 1 : q;
                r.new_noise = 32'(clamp(longint'(noi) + qf, longint'(S32_MIN),
                                        longint'(S32_MAX)));
            end
        end
        r.flux_total = sum_flux;
        r.pixel_count = sum_count;
        r.mean_out = sum_mean;
        return r;
    endfunction

    task automatic write_register(input cfg_idx_t idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        case (idx)
            REG_CENTER_X:   shadow_cfg.center_x = value[15:0];
            REG_CENTER_Y:   shadow_cfg.center_y = value[15:0];
            REG_AXIS_A:     shadow_cfg.axis_a = value[11:0];
            REG_AXIS_B:     shadow_cfg.axis_b = value[11:0];
            REG_COS_ANGLE:  shadow_cfg.cos_angle = value[15:0];
            REG_SIN_ANGLE:  shadow_cfg.sin_angle = value[15:0];
            REG_SKY_LEVEL:  shadow_cfg.sky_level = value;
            REG_NOISE_GAIN: shadow_cfg.noise_gain = value[15:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        int guard;
        s_tvalid <= 1'b0;
        guard = 0;
        while (expected_pixels.size() != 0 && guard < 200000) begin
            @(posedge aclk);
            guard++;
        end
        if (expected_pixels.size() != 0) begin
            $display("*** FAILED ***");
            $finish;
        end
        repeat (80) @(posedge aclk);
    endtask

    task automatic configure(input logic [15:0] cx, input logic [15:0] cy,
                             input logic [11:0] a, input logic [11:0] b,
                             input logic [15:0] c, input logic [15:0] s,
                             input logic [31:0] sky, input logic [15:0] gain);
        wait_drained();
        write_register(REG_CENTER_X, 32'(cx));
        write_register(REG_CENTER_Y, 32'(cy));
        write_register(REG_AXIS_A, 32'(a));
        write_register(REG_AXIS_B, 32'(b));
        write_register(REG_COS_ANGLE, 32'(c));
        write_register(REG_SIN_ANGLE, 32'(s));
        write_register(REG_SKY_LEVEL, sky);
        write_register(REG_NOISE_GAIN, 32'(gain));
        cfg_valid <= 1'b0;
    endtask

    task automatic send_pixel(input logic func, input logic [11:0] col,
                              input logic [11:0] row, input logic [31:0] pix,
                              input logic [31:0] noi, input logic gaps);
        int idle;
        idle = gaps && ($urandom_range(0, 2) == 0) ? $urandom_range(0, 14) : 0;
        if (idle > 0) begin
            s_tvalid <= 1'b0;
            repeat (idle) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= func;
        s_tdata <= {noi, pix, row, col};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        expected_pixels.push_back(predict_pixel(func, col, row, pix, noi));
    endtask

    always @(posedge aclk) begin
        aperture_result_t got;
        aperture_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[RESULT_BITS-1:0];
            if (expected_pixels.size() == 0) begin
                report_mismatch("unexpected result", m_tdata[63:0], 64'd0);
            end else begin
                want = expected_pixels.pop_front();
                if (got.new_pixel !== want.new_pixel)
                    report_mismatch("new_pixel", 64'(got.new_pixel), 64'(want.new_pixel));
                if (got.new_noise !== want.new_noise)
                    report_mismatch("new_noise", 64'(got.new_noise), 64'(want.new_noise));
                if (got.inside_core !== want.inside_core)
                    report_mismatch("inside_core", 64'(got.inside_core),
                                    64'(want.inside_core));
                if (got.inside_halo !== want.inside_halo)
                    report_mismatch("inside_halo", 64'(got.inside_halo),
                                    64'(want.inside_halo));
                if (got.flux_total !== want.flux_total)
                    report_mismatch("flux_total", 64'(got.flux_total), 64'(want.flux_total));
                if (got.pixel_count !== want.pixel_count)
                    report_mismatch("pixel_count", 64'(got.pixel_count),
                                    64'(want.pixel_count));
                if (got.mean_out !== want.mean_out)
                    report_mismatch("mean_out", 64'(got.mean_out), 64'(want.mean_out));
            end
        end
    end

    always begin
        int hold;
        hold = stall_max == 0 ? 0 : $urandom_range(0, stall_max);
        if (hold > 0) begin
            m_tready <= 1'b0;
            repeat (hold) @(posedge aclk);
        end
        m_tready <= 1'b1;
        @(posedge aclk);
        while (!(m_tvalid && m_tready))
            @(posedge aclk);
    end

    // Pixels near the ellipse centre, so that most land inside or near the aperture.
    task automatic send_near(input logic func, input logic gaps);
        int spread;
        int c;
        int r;
        spread = (int'(shadow_cfg.axis_a > shadow_cfg.axis_b ? shadow_cfg.axis_a
                                                             : shadow_cfg.axis_b) + 48) / 16;
        c = int'(shadow_cfg.center_x / 16) + $urandom_range(0, 2 * spread) - spread;
        r = int'(shadow_cfg.center_y / 16) + $urandom_range(0, 2 * spread) - spread;
        c = c < 0 ? 0 : (c > 4095 ? 4095 : c);
        r = r < 0 ? 0 : (r > 4095 ? 4095 : r);
        send_pixel(func, 12'(c), 12'(r),
                   $urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 65535),
                   $urandom, gaps);
    endtask

    task automatic test_directed_extremes();
        configure(16'd800, 16'd800, 12'd160, 12'd96, 16'sd16384, 16'sd0, 32'sd256, 16'd256);
        send_pixel(1'b0, 12'd50, 12'd50, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        send_pixel(1'b0, 12'd48, 12'd50, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        send_pixel(1'b0, 12'd0, 12'd0, 32'h1234_5678, 32'h0, 1'b0);
        send_pixel(1'b0, 12'd4095, 12'd4095, 32'h0, 32'hFFFF_FFFF, 1'b0);
        send_pixel(1'b0, 12'd59, 12'd50, 32'd1000, 32'd5, 1'b0);
        send_pixel(1'b1, 12'd50, 12'd50, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        send_pixel(1'b1, 12'd60, 12'd50, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        send_pixel(1'b1, 12'd4095, 12'd0, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
        // A measure request in the apply pass restarts the measurement.
        send_pixel(1'b0, 12'd50, 12'd50, 32'd300, 32'd0, 1'b0);
        configure(16'd800, 16'd800, 12'd0, 12'd160, 16'hC000, 16'sd16384, 32'h8000_0000,
                  16'hFFFF);
        send_pixel(1'b0, 12'd50, 12'd50, 32'd1, 32'd2, 1'b0);
        send_pixel(1'b1, 12'd50, 12'd50, 32'd1, 32'd2, 1'b0);
        configure(16'hFFFF, 16'h0, 12'hFFF, 12'hFFF, 16'h4000, 16'hC000, 32'h7FFF_FFFF, 16'd0);
        send_pixel(1'b0, 12'd4095, 12'd0, 32'h7FFF_FFFF, 32'd0, 1'b0);
        send_pixel(1'b0, 12'd4000, 12'd100, 32'h8000_0000, 32'd0, 1'b0);
        send_pixel(1'b1, 12'd4095, 12'd0, 32'd0, 32'h7FFF_FFFF, 1'b0);
        send_pixel(1'b1, 12'd4090, 12'd5, 32'h8000_0000, 32'h8000_0000, 1'b0);
    endtask

    task automatic test_random_passes(input int passes);
        int n;
        for (int p = 0; p < passes; p++) begin
            stall_max = (p % 3 == 0) ? 0 : 14;
            configure(16'($urandom), 16'($urandom),
                      12'($urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 255)),
                      12'($urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 255)),
                      16'($urandom_range(0, 32768) - 16384),
                      16'($urandom_range(0, 32768) - 16384),
                      $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 4095),
                      16'($urandom));
            n = $urandom_range(30, 60);
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 9) == 0)
                    send_pixel(1'b0, 12'($urandom), 12'($urandom), $urandom, $urandom,
                               p % 3 != 0);
                else
                    send_near(1'b0, p % 3 != 0);
            end
            n = $urandom_range(30, 60);
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 9) == 0)
                    send_pixel(1'b1, 12'($urandom), 12'($urandom), $urandom, $urandom,
                               p % 3 != 0);
                else
                    send_near(1'b1, p % 3 != 0);
            end
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_CENTER_X;
        cfg_data = '0;
        error_count = 0;
        stall_max = 0;
        shadow_cfg = '{center_x: 16'd0, center_y: 16'd0, axis_a: 12'd0, axis_b: 12'd0,
                       cos_angle: 16'sd16384, sin_angle: 16'sd0, sky_level: 32'sd0,
                       noise_gain: 16'd256};
        sum_flux = '0;
        sum_count = '0;
        sum_mean = '0;
        in_apply = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_extremes();
        test_random_passes(15);
        wait_drained();
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
